@@ sv/fac_pkg.sv @@
// ----------------------------------------------------------------------------
// fac_pkg
// Shared constants and functions for the frustum box culler.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PLANE_COUNT = 6;
  localparam logic [31:0] EPS_Q = 32'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [31:0] MARGIN_RESET =
    -32'sd1 * 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [2:0] MODE_VIEW  = 3'd0;
  localparam logic [2:0] MODE_PROJ  = 3'd1;
  localparam logic [2:0] MODE_BUILD = 3'd2;
  localparam logic [2:0] MODE_MODEL = 3'd3;
  localparam logic [2:0] MODE_TEST  = 3'd4;

  // signed 32 x 32 product shifted down with floor rounding (arith shift)
  function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 48'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ sv/fac_div.sv @@
// ----------------------------------------------------------------------------
// fac_div
// Restoring divider and square root, one bit per cycle, for plane normalising.
// ----------------------------------------------------------------------------
module fac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               sqrt_i,
  input  logic signed [31:0] num_i,
  input  logic [63:0]        rad_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);

  localparam int FracShift = fac_pkg::FRAC_BITS;

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, sqrt_q, sqrt_d, neg_q, neg_d;
  logic [63:0] x_q, x_d, r_q, r_d;
  logic [64:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [64:0] trial;
  logic [63:0] one;
  logic [63:0] mag;

  assign one = 64'd1 << {cnt_q[5:0], 1'b0};

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; sqrt_d = sqrt_q; neg_d = neg_q;
    x_d = x_q; r_d = r_q; rem_d = rem_q; den_d = den_q;
    done_o = 1'b0;
    trial = '0;
    mag = '0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      den_d  = den_i;
      neg_d  = num_i[31];
      r_d    = '0;
      rem_d  = '0;
      if (sqrt_i) begin
        x_d = rad_i; cnt_d = 7'd31;
      end else begin
        mag = num_i[31] ? 64'(-65'(num_i)) : 64'(num_i);
        x_d = mag << FracShift; cnt_d = 7'd63;
      end
    end else if (busy_q) begin
      if (sqrt_q) begin
        trial = 65'(r_q) + 65'(one);
        if (65'(x_q) >= trial) begin
          x_d = x_q - trial[63:0];
          r_d = (r_q >> 1) + one;
        end else begin
          r_d = r_q >> 1;
        end
      end else begin
        trial = {rem_q[63:0], x_q[63]};
        x_d = {x_q[62:0], 1'b0};
        if (trial >= 65'(den_q)) begin
          rem_d = trial - 65'(den_q);
          r_d = {r_q[62:0], 1'b1};
        end else begin
          rem_d = trial;
          r_d = {r_q[62:0], 1'b0};
        end
      end
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0; done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  logic signed [64:0] q_s;
  always_comb begin
    q_s = neg_q ? -65'(r_d) : 65'(r_d);
    if (sqrt_q) res_o = r_d[31:0];
    else res_o = fac_pkg::sat32(50'(q_s > 65'sd2147483647 ? 65'sd2147483648 :
                               (q_s < -65'sd2147483648 ? -65'sd2147483649 : q_s)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; sqrt_q <= 1'b0; neg_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; sqrt_q <= sqrt_d; neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; rem_q <= rem_d; den_q <= den_d;
  end

endmodule

@@ sv/frustum_aabb_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_aabb_cull
// Frustum plane build and model-space box culling on one shared multiplier.
// ----------------------------------------------------------------------------
// channel  | signals                                   | direction
// command  | start_i, busy_o, mode_i .. box_max_z_i    | in
// result   | res_valid_o, visible_o, degenerate_box_o  | out
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i      | in
// A build forms the view-projection products, then per plane the row sums, 3 squares,
// a square root and, when normalised, 4 divisions. A box test transforms the corners
// and runs dot products until a plane culls; a degenerate box or no valid planes skip
// both. Each test ends in S_OUT and the strobe follows in the next cycle. busy_o is
// high while a transaction works, cfg_ready_o is low meanwhile; results cannot be stalled.
// Reset clears pvalid_q and sets the margin to -0.1.
// ----------------------------------------------------------------------------
module frustum_aabb_cull (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         mode_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic               camera_present_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  output logic               res_valid_o,
  output logic               visible_o,
  output logic               degenerate_box_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [31:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_VP    = 9'b000000010,
    S_ROW   = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_XF    = 9'b001000000,
    S_DOT   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] view_q [16];
  logic signed [31:0] proj_q [16];
  logic signed [31:0] model_q [16];
  logic signed [31:0] vp_q [16];
  logic signed [31:0] plane_q [24];
  logic signed [31:0] corner_q [24];
  logic signed [31:0] bmin_q [3];
  logic signed [31:0] bmax_q [3];
  logic               pvalid_q;
  logic signed [31:0] margin_q;

  logic [3:0]  a_q;      // outer index (element / coordinate); start flag in S_DIV
  logic [2:0]  k_q;      // term index
  logic [2:0]  j_q;      // plane
  logic [3:0]  i_q;      // corner
  logic signed [49:0] acc_q;
  logic [63:0] sq_q;
  logic [31:0] len_q;
  logic        inside_q, vis_q, deg_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] sqp;
  logic signed [47:0] prod;
  assign sqp = 64'(ma) * 64'(mb);
  assign prod = 48'(sqp >>> fac_pkg::FRAC_BITS);

  logic        dv_start, dv_sqrt, dv_done;
  logic signed [31:0] dv_num, dv_res;

  fac_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .sqrt_i(dv_sqrt), .num_i(dv_num),
    .rad_i(sq_q), .den_i(len_q), .done_o(dv_done), .res_o(dv_res)
  );

  logic start_acc;
  assign start_acc = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;

  // multiplier operand selection
  logic [1:0] row;
  logic [4:0] pidx, cidx;
  logic signed [31:0] pt;
  always_comb begin
    row = 2'(j_q >> 1);
    pidx = 5'({j_q, 2'b00}) + 5'(k_q);
    cidx = 5'(i_q[2:0]) * 5'd3 + 5'(k_q);
    case (k_q[1:0])
      2'd0: pt = i_q[0] ? bmax_q[0] : bmin_q[0];
      2'd1: pt = i_q[1] ? bmax_q[1] : bmin_q[1];
      default: pt = i_q[2] ? bmax_q[2] : bmin_q[2];
    endcase
    ma = '0; mb = '0;
    case (state_q)
      S_VP: begin
        ma = proj_q[{k_q[1:0], a_q[1:0]}]; mb = view_q[{a_q[3:2], k_q[1:0]}];
      end
      S_SQ: begin
        ma = plane_q[pidx]; mb = plane_q[pidx];
      end
      S_XF: begin
        ma = model_q[{k_q[1:0], a_q[1:0]}]; mb = pt;
      end
      S_DOT: begin
        ma = plane_q[pidx]; mb = corner_q[cidx];
      end
      default: ;
    endcase
  end

  logic degen_in;
  assign degen_in = (box_min_x_i >= box_max_x_i) || (box_min_y_i >= box_max_y_i) ||
                    (box_min_z_i >= box_max_z_i);

  logic signed [32:0] ra, rb;
  logic signed [31:0] dsat;
  assign dsat = fac_pkg::sat32(acc_q + 50'(prod));

  always_comb begin
    state_d = state_q;
    dv_start = 1'b0; dv_sqrt = 1'b0;
    dv_num = plane_q[pidx];
    ra = 33'(vp_q[{k_q[1:0], 2'd3}]);
    rb = 33'(vp_q[{k_q[1:0], row}]);
    case (state_q)
      S_IDLE: if (start_acc) begin
        if (mode_i == fac_pkg::MODE_BUILD && camera_present_i) state_d = S_VP;
        else if (mode_i == fac_pkg::MODE_TEST) state_d = S_OUT;
      end
      S_VP:  if (k_q == 3'd3 && a_q == 4'd15) state_d = S_ROW;
      S_ROW: if (k_q == 3'd3) state_d = S_SQ;
      S_SQ:  if (k_q == 3'd2) state_d = S_SQRT;
      S_SQRT: begin
        dv_sqrt = 1'b1;
        dv_start = (k_q == 3'd0);
        if (dv_done) begin
          if (dv_res > fac_pkg::EPS_Q) state_d = S_DIV;
          else if (j_q == 3'd5) state_d = S_IDLE;
          else state_d = S_ROW;
        end
      end
      S_DIV: begin
        dv_start = !a_q[0];
        if (dv_done && k_q == 3'd3) state_d = (j_q == 3'd5) ? S_IDLE : S_ROW;
      end
      S_XF:  if (k_q == 3'd2 && a_q[1:0] == 2'd2 && i_q == 4'd7) state_d = S_DOT;
      S_DOT: if (k_q == 3'd2) begin
        if (dsat > margin_q || i_q == 4'd7) begin
          if (!(dsat > margin_q || inside_q) || j_q == 3'd5) state_d = S_OUT;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic test_go;
  assign test_go = start_acc && mode_i == fac_pkg::MODE_TEST && pvalid_q && !degen_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pvalid_q <= 1'b0; margin_q <= fac_pkg::MARGIN_RESET;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= test_go ? S_XF : state_d;
      res_valid_o <= (state_q == S_OUT);
      if (cfg_valid_i && cfg_ready_o) margin_q <= cfg_data_i;
      if (start_acc && mode_i == fac_pkg::MODE_BUILD) pvalid_q <= camera_present_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_acc) begin
      a_q <= '0; k_q <= '0; j_q <= '0; i_q <= '0;
      acc_q <= (mode_i == fac_pkg::MODE_TEST) ? 50'(model_q[12]) : '0;
      inside_q <= 1'b0; vis_q <= 1'b1; deg_q <= degen_in;
      bmin_q[0] <= box_min_x_i; bmin_q[1] <= box_min_y_i; bmin_q[2] <= box_min_z_i;
      bmax_q[0] <= box_max_x_i; bmax_q[1] <= box_max_y_i; bmax_q[2] <= box_max_z_i;
      case (mode_i)
        fac_pkg::MODE_VIEW:  view_q[elem_index_i] <= elem_value_i;
        fac_pkg::MODE_PROJ:  proj_q[elem_index_i] <= elem_value_i;
        fac_pkg::MODE_MODEL: model_q[elem_index_i] <= elem_value_i;
        default: ;
      endcase
    end else begin
      case (state_q)
        S_VP: begin
          if (k_q == 3'd3) begin
            vp_q[a_q] <= dsat;
            acc_q <= '0; k_q <= '0; a_q <= a_q + 4'd1;
          end else begin
            acc_q <= acc_q + 50'(prod); k_q <= k_q + 3'd1;
          end
        end
        S_ROW: begin
          plane_q[{j_q, k_q[1:0]}] <= fac_pkg::sat32(50'(j_q[0] ? ra - rb : ra + rb));
          k_q <= (k_q == 3'd3) ? 3'd0 : k_q + 3'd1;
          sq_q <= '0;
        end
        S_SQ: begin
          sq_q <= sq_q + sqp;
          k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
        end
        S_SQRT: begin
          k_q <= dv_done ? 3'd0 : 3'd1;
          if (dv_done) begin
            len_q <= dv_res; a_q <= '0;
            if (!(dv_res > fac_pkg::EPS_Q)) j_q <= j_q + 3'd1;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            plane_q[pidx] <= dv_res; a_q[0] <= 1'b0;
            if (k_q == 3'd3) begin
              k_q <= '0; j_q <= j_q + 3'd1;
            end else k_q <= k_q + 3'd1;
          end else if (!a_q[0]) begin
            a_q[0] <= 1'b1;
          end
        end
        S_XF: begin
          if (k_q == 3'd2) begin
            corner_q[5'(i_q[2:0]) * 5'd3 + 5'(a_q[1:0])] <= dsat;
            k_q <= '0;
            if (a_q[1:0] == 2'd2) begin
              a_q <= '0;
              if (i_q == 4'd7) begin
                i_q <= '0; acc_q <= 50'(plane_q[3]);
              end else begin
                i_q <= i_q + 4'd1; acc_q <= 50'(model_q[12]);
              end
            end else begin
              a_q <= a_q + 4'd1;
              acc_q <= 50'(model_q[4'd13 + {2'b00, a_q[1:0]}]);
            end
          end else begin
            acc_q <= acc_q + 50'(prod); k_q <= k_q + 3'd1;
          end
        end
        S_DOT: begin
          if (k_q == 3'd2) begin
            k_q <= '0;
            if (dsat > margin_q || i_q == 4'd7) begin
              if (!(dsat > margin_q)) vis_q <= 1'b0;
              i_q <= '0; j_q <= j_q + 3'd1;
              acc_q <= 50'(plane_q[{j_q + 3'd1, 2'd3}]);
            end else begin
              i_q <= i_q + 4'd1; acc_q <= 50'(plane_q[{j_q, 2'd3}]);
            end
          end else begin
            acc_q <= acc_q + 50'(prod); k_q <= k_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign visible_o = vis_q;
  assign degenerate_box_o = deg_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o) else $error("result while busy");
  a_deg_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && degenerate_box_o) |-> visible_o) else $error("degenerate culled");
`endif

endmodule

@@ sim/frustum_aabb_cull_checker.sv @@
// ----------------------------------------------------------------------------
// frustum_aabb_cull_checker
// Watches the command, result and config channels of the frustum box culler,
// keeps its own copy of matrices, planes and margin, predicts each box verdict
// and compares it with the result strobe in order.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_checker
  import fac_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         mode_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic               camera_present_i,
  input  logic signed [31:0] box_min_x_i,
  input  logic signed [31:0] box_min_y_i,
  input  logic signed [31:0] box_min_z_i,
  input  logic signed [31:0] box_max_x_i,
  input  logic signed [31:0] box_max_y_i,
  input  logic signed [31:0] box_max_z_i,
  input  logic               res_valid_i,
  input  logic               visible_i,
  input  logic               degenerate_box_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic signed [31:0] cfg_data_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o,
  output int                 box_tests_o,
  output int                 culled_o,
  output int                 degenerate_o,
  output int                 builds_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic visible;
    logic degenerate;
  } verdict_t;

  logic signed [31:0] view_m  [16];
  logic signed [31:0] proj_m  [16];
  logic signed [31:0] model_m [16];
  logic signed [31:0] plane_m [PLANE_COUNT*4];
  logic               planes_ok;
  logic signed [31:0] margin;
  verdict_t           verdict_q [$];

  assign pending_o = verdict_q.size();

  function automatic longint qprod(input logic signed [31:0] a, input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned rem, res, b;
    rem = x;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic build_frustum();
    logic signed [31:0] vp [16];
    longint             s, a, b;
    longint unsigned    sq, len;
    int                 row;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += qprod(proj_m[k*4+r], view_m[c*4+k]);
        vp[c*4+r] = clamp32(s);
      end
    for (int j = 0; j < PLANE_COUNT; j++) begin
      row = (j / 2) & 3;
      sq = 0;
      for (int c = 0; c < 4; c++) begin
        a = vp[c*4+3];
        b = vp[c*4+row];
        plane_m[j*4+c] = clamp32((j & 1) ? a - b : a + b);
      end
      for (int c = 0; c < 3; c++) begin
        a = plane_m[j*4+c];
        sq += longint'(a * a);
      end
      len = root64(sq);
      if (len > {32'd0, EPS_Q})
        for (int c = 0; c < 4; c++)
          plane_m[j*4+c] = clamp32((longint'(plane_m[j*4+c]) * (64'sd1 <<< FRAC_BITS))
                                   / longint'(len));
    end
    planes_ok = 1'b1;
  endtask

  function automatic verdict_t judge_box();
    logic signed [31:0] lo [3], hi [3], pt [3];
    logic signed [31:0] corner [8][3];
    longint             s;
    logic               hit;
    verdict_t           v;
    lo = '{box_min_x_i, box_min_y_i, box_min_z_i};
    hi = '{box_max_x_i, box_max_y_i, box_max_z_i};
    v.visible = 1'b1;
    v.degenerate = 1'b0;
    for (int a = 0; a < 3; a++) if (lo[a] >= hi[a]) v.degenerate = 1'b1;
    if (planes_ok && !v.degenerate) begin
      for (int i = 0; i < 8; i++) begin
        for (int a = 0; a < 3; a++) pt[a] = ((i >> a) & 1) ? hi[a] : lo[a];
        for (int r = 0; r < 3; r++) begin
          s = longint'(model_m[12+r]);
          for (int a = 0; a < 3; a++) s += qprod(model_m[a*4+r], pt[a]);
          corner[i][r] = clamp32(s);
        end
      end
      for (int j = 0; j < PLANE_COUNT && v.visible; j++) begin
        hit = 1'b0;
        for (int i = 0; i < 8 && !hit; i++) begin
          s = longint'(plane_m[j*4+3]);
          for (int a = 0; a < 3; a++) s += qprod(plane_m[j*4+a], corner[i][a]);
          if (clamp32(s) > margin) hit = 1'b1;
        end
        if (!hit) v.visible = 1'b0;
      end
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        view_m[i] = '0;
        proj_m[i] = '0;
        model_m[i] = '0;
      end
      for (int i = 0; i < PLANE_COUNT*4; i++) plane_m[i] = '0;
      planes_ok = 1'b0;
      margin = MARGIN_RESET;
      verdict_q.delete();
      mismatch_cnt_o = 0;
      box_tests_o = 0;
      culled_o = 0;
      degenerate_o = 0;
      builds_o = 0;
    end else begin
      if (res_valid_i) begin
        if (verdict_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%t: result with none outstanding: visible %0b degenerate %0b",
                     $realtime, visible_i, degenerate_box_i);
        end else begin
          want = verdict_q.pop_front();
          if (visible_i !== want.visible || degenerate_box_i !== want.degenerate) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("%t: box mismatch: visible exp %0b got %0b, degenerate exp %0b got %0b",
                       $realtime, want.visible, visible_i, want.degenerate, degenerate_box_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) margin = cfg_data_i;
      if (start_i && !busy_i) begin
        case (mode_i)
          MODE_VIEW:  view_m[elem_index_i] = elem_value_i;
          MODE_PROJ:  proj_m[elem_index_i] = elem_value_i;
          MODE_MODEL: model_m[elem_index_i] = elem_value_i;
          MODE_BUILD: begin
            builds_o++;
            if (camera_present_i) build_frustum();
            else planes_ok = 1'b0;
          end
          MODE_TEST: begin
            want = judge_box();
            box_tests_o++;
            if (!want.visible) culled_o++;
            if (want.degenerate) degenerate_o++;
            verdict_q = {verdict_q, want};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ sim/frustum_aabb_cull_tb.sv @@
// ----------------------------------------------------------------------------
// frustum_aabb_cull_tb
// Drives matrix loads, plane builds and box tests into the culler with random
// gaps and several margin settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_tb;
  import fac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int        LIMIT = 3_000_000;
  localparam int        ONE   = 1 << FRAC_BITS;

  typedef struct {
    logic [2:0]         mode;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               cam;
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
  } cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         mode_i = '0;
  logic [3:0]         elem_index_i = '0;
  logic signed [31:0] elem_value_i = '0;
  logic               camera_present_i = 1'b0;
  logic signed [31:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [31:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic               res_valid_o, visible_o, degenerate_box_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic signed [31:0] cfg_data_i = '0;

  int mismatch_cnt, pending, box_tests, culled, degenerate, builds;
  int cycles = 0;
  int items = 0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frustum_aabb_cull u_dut (.*);

  frustum_aabb_cull_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .elem_index_i, .elem_value_i,
    .camera_present_i, .box_min_x_i, .box_min_y_i, .box_min_z_i, .box_max_x_i,
    .box_max_y_i, .box_max_z_i, .res_valid_i(res_valid_o), .visible_i(visible_o),
    .degenerate_box_i(degenerate_box_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_data_i, .mismatch_cnt_o(mismatch_cnt), .pending_o(pending),
    .box_tests_o(box_tests), .culled_o(culled), .degenerate_o(degenerate),
    .builds_o(builds)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [31:0] span(input int lim_units);
    return $signed($urandom_range(0, 2 * lim_units * ONE)) - lim_units * ONE;
  endfunction

  task automatic issue(input cmd_t c);
    mode_i <= c.mode;
    elem_index_i <= c.idx;
    elem_value_i <= c.val;
    camera_present_i <= c.cam;
    box_min_x_i <= c.lo[0];
    box_min_y_i <= c.lo[1];
    box_min_z_i <= c.lo[2];
    box_max_x_i <= c.hi[0];
    box_max_y_i <= c.hi[1];
    box_max_z_i <= c.hi[2];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    if (c.mode <= MODE_TEST) items++;
    begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        start_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  function automatic cmd_t noise_cmd(input logic [2:0] m);
    cmd_t c;
    c.mode = m;
    c.idx = $urandom();
    c.val = $urandom();
    c.cam = $urandom();
    for (int a = 0; a < 3; a++) begin
      c.lo[a] = $urandom();
      c.hi[a] = $urandom();
    end
    return c;
  endfunction

  task automatic load(input logic [2:0] m, input logic [3:0] idx, input logic signed [31:0] v);
    cmd_t c;
    c = noise_cmd(m);
    c.idx = idx;
    c.val = v;
    issue(c);
  endtask

  task automatic build(input logic cam);
    cmd_t c;
    c = noise_cmd(MODE_BUILD);
    c.cam = cam;
    issue(c);
  endtask

  task automatic test_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
    cmd_t c;
    c = noise_cmd(MODE_TEST);
    c.lo = '{lx, ly, lz};
    c.hi = '{hx, hy, hz};
    issue(c);
  endtask

  // kind 0 camera-like, 1 small random, 2 full-range random
  function automatic logic signed [31:0] mat_val(input int kind, input logic [2:0] m,
                                                 input int idx);
    if (kind == 2) return $urandom();
    if (kind == 1) return span(8);
    case (m)
      MODE_VIEW: begin
        if (idx == 15) return ONE;
        if (idx == 3 || idx == 7 || idx == 11) return 0;
        if (idx >= 12) return span(4);
        if (idx % 5 == 0) return ONE + span(1) / 4;
        return span(1) / 4;
      end
      MODE_PROJ: begin
        if (idx == 0 || idx == 5) return $urandom_range(ONE / 2, 3 * ONE);
        if (idx == 10) return -$signed($urandom_range(ONE, ONE + ONE / 8));
        if (idx == 11) return -ONE;
        if (idx == 14) return -$signed($urandom_range(ONE / 10, ONE));
        return 0;
      end
      default: begin
        if (idx == 15) return ONE;
        if (idx == 3 || idx == 7 || idx == 11) return 0;
        if (idx >= 12) return span(8);
        if (idx % 5 == 0) return $urandom_range(ONE / 4, 4 * ONE);
        return span(1) / 2;
      end
    endcase
  endfunction

  task automatic load_all(input int kind);
    logic [2:0] mats [3];
    int         k;
    mats = '{MODE_VIEW, MODE_PROJ, MODE_MODEL};
    foreach (mats[n]) begin
      k = $urandom_range(0, 15);
      for (int i = 0; i < 16; i++)
        load(mats[n], 4'((i * 5 + k) & 15), mat_val(kind, mats[n], (i * 5 + k) & 15));
    end
  endtask

  task automatic random_box(input bit wild);
    logic signed [31:0] lo [3], hi [3];
    int                 r;
    for (int a = 0; a < 3; a++) begin
      if (wild) begin
        lo[a] = $urandom();
        hi[a] = $urandom();
      end else begin
        lo[a] = span(20);
        hi[a] = lo[a] + $urandom_range(ONE / 100, 5 * ONE);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 5) hi[$urandom_range(0, 2)] = lo[0];
    else if (r < 8) begin
      int a;
      a = $urandom_range(0, 2);
      hi[a] = lo[a];
    end
    test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_margin(input logic signed [31:0] m);
    settle();
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic signed [31:0] margins [8];
    int                 r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity view and model, simple perspective
    for (int i = 0; i < 16; i++) begin
      load(MODE_VIEW, 4'(i), (i % 5 == 0) ? ONE : 0);
      load(MODE_MODEL, 4'(i), (i % 5 == 0) ? ONE : 0);
      load(MODE_PROJ, 4'(i), 0);
    end
    test_box(-ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE);
    build(1'b1);   // all-zero projection: every plane too short to normalise
    test_box(-ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE);
    load(MODE_PROJ, 4'd0, ONE);
    load(MODE_PROJ, 4'd5, ONE);
    load(MODE_PROJ, 4'd10, -ONE);
    load(MODE_PROJ, 4'd11, -ONE);
    load(MODE_PROJ, 4'd14, -ONE / 5);
    build(1'b1);
    test_box(-ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE);
    test_box(-ONE, -ONE, 4 * ONE, ONE, ONE, 6 * ONE);
    test_box(40 * ONE, -ONE, -6 * ONE, 42 * ONE, ONE, -4 * ONE);
    test_box(ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE);
    test_box(-ONE, ONE, -6 * ONE, ONE, -ONE, -4 * ONE);
    test_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             32'sh80000000, 32'sh80000000, 32'sh80000000);
    load(MODE_MODEL, 4'd12, 32'sh7fffffff);
    load(MODE_MODEL, 4'd0, 32'sh80000000);
    test_box(-ONE, -ONE, -6 * ONE, ONE, ONE, -4 * ONE);
    load(MODE_MODEL, 4'd12, 0);
    load(MODE_MODEL, 4'd0, ONE);
    issue(noise_cmd(3'd5));
    issue(noise_cmd(3'd6));
    issue(noise_cmd(3'd7));
    build(1'b0);
    test_box(-ONE, -ONE, 4 * ONE, ONE, ONE, 6 * ONE);
    test_box(ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE);

    margins = '{MARGIN_RESET, 32'sh80000000, 32'sh7fffffff, 0,
                span(2), $urandom(), MARGIN_RESET, span(1)};
    for (int p = 0; p < 8; p++) begin
      write_margin(margins[p]);
      no_gaps = (p % 3 == 1);
      load_all(p == 5 ? 1 : (p == 6 ? 2 : 0));
      build(1'b1);
      for (int n = 0; n < 150; n++) begin
        if (p == 3 && n == 75) settle();
        r = $urandom_range(0, 99);
        if (r < 76) random_box(1'b0);
        else if (r < 84) begin
          logic [2:0] m;
          logic [3:0] ix;
          m = (r < 80) ? MODE_MODEL : ((r < 82) ? MODE_VIEW : MODE_PROJ);
          ix = $urandom();
          load(m, ix, mat_val(p == 6 ? 2 : $urandom_range(0, 1), m, ix));
        end else if (r < 89) build(1'b1);
        else if (r < 91) build(1'b0);
        else if (r < 94) begin
          issue(noise_cmd(3'($urandom_range(5, 7))));
          n--;
        end else random_box(1'b1);
      end
    end

    settle();
    repeat (200) @(posedge clk_i);
    $display("Ran %0d items: %0d box tests (%0d culled, %0d degenerate), %0d plane builds,",
             items, box_tests, culled, degenerate, builds);
    $display("over eight margin settings including both extremes.");
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d verdicts outstanding", mismatch_cnt, pending);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/fac_pkg.sv
sv/fac_div.sv
sv/frustum_aabb_cull.sv
sim/frustum_aabb_cull_checker.sv
sim/frustum_aabb_cull_tb.sv
